>>> rtl/sfd_pkg.sv
// sfd_pkg: shared constants, types and controller states for the serial frame deframer
// no dependencies
package sfd_pkg;

    localparam int MAX_PAYLOAD = 30;
    localparam int HDR_BYTES   = 5;
    localparam int CRC_BYTES   = 2;
    localparam int STORE_DEPTH = HDR_BYTES + MAX_PAYLOAD + CRC_BYTES;
    localparam int CNT_W       = $clog2(STORE_DEPTH);
    localparam int LEN_W       = $clog2(MAX_PAYLOAD + 1);

    localparam logic [7:0]  START_BYTE = 8'hCC;
    localparam logic [7:0]  LEAD_BYTE  = 8'h64;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'h1021;

    typedef enum logic [2:0] {
        ST_HUNT,
        ST_RECV,
        ST_FETCH,
        ST_LOAD
    } state_t;

    typedef struct packed {
        logic clear;
        logic accept;
        logic set_len;
        logic latch_good;
        logic rd_start;
        logic rd_en;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic is_start;
        logic lead_ok;
        logic first_byte;
        logic len_byte;
        logic len_bad;
        logic frame_end;
        logic crc_match;
        logic ignore;
        logic rd_last;
        logic out_free;
    } status_t;

endpackage

>>> rtl/sfd_rx_if.sv
// sfd_rx_if: input channel carrying one received serial byte per item
// depends on nothing
interface sfd_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

>>> rtl/sfd_tx_if.sv
// sfd_tx_if: output channel carrying one byte of an accepted frame per item
// depends on nothing
interface sfd_tx_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       last_of_frame;
    logic       crc_good;

    modport source (output valid, output frame_byte, output last_of_frame, output crc_good,
                    input ready);
    modport sink (input valid, input frame_byte, input last_of_frame, input crc_good,
                  output ready);
endinterface

>>> rtl/serial_frame_deframer_crc16.sv
// Serial frame deframer with CRC-16/CCITT-FALSE check. One received byte is taken per
// cycle while hunting for the 0xCC start byte or storing a frame. When the last CRC byte
// of a frame arrives and the CRC matches (or ignore_crc_errors is set), the stored frame,
// from the 0x64 byte through the CRC low byte, is replayed from a 37-byte frame store. Each
// byte is read from the store's registered read port, then loaded into the output register
// once it is free; no input is taken during the replay, so a frame of 7 + length bytes
// blocks the input until its last byte is loaded. The output register lets the next frame's
// input start while the final byte still waits to be taken. No clearing pass follows reset.
// depends on sfd_pkg, sfd_rx_if, sfd_tx_if, sfd_ctrl, sfd_datapath
module serial_frame_deframer_crc16 (
    input  logic   clk,
    input  logic   rst_n,
    input  logic   cfg_write_en,
    input  logic   cfg_write_data,
    sfd_rx_if.sink rx,
    sfd_tx_if.source tx
);

    sfd_pkg::cmd_t    cmd;
    sfd_pkg::status_t status;

    sfd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (rx.valid),
        .in_ready (rx.ready),
        .status   (status),
        .cmd      (cmd)
    );

    sfd_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .rx_byte        (rx.rx_byte),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .out_ready      (tx.ready),
        .out_valid      (tx.valid),
        .frame_byte     (tx.frame_byte),
        .last_of_frame  (tx.last_of_frame),
        .crc_good       (tx.crc_good)
    );

endmodule

>>> rtl/sfd_datapath.sv
// sfd_datapath: frame store, byte counter, crc register, replay pointer and output register
// depends on sfd_pkg
module sfd_datapath (
    input  logic             clk,
    input  logic             rst_n,
    input  sfd_pkg::cmd_t    cmd,
    output sfd_pkg::status_t status,
    input  logic [7:0]       rx_byte,
    input  logic             cfg_write_en,
    input  logic             cfg_write_data,
    input  logic             out_ready,
    output logic             out_valid,
    output logic [7:0]       frame_byte,
    output logic             last_of_frame,
    output logic             crc_good
);

    logic [7:0] store_mem [sfd_pkg::STORE_DEPTH];

    logic [sfd_pkg::CNT_W-1:0] count_reg, count_next;
    logic [sfd_pkg::LEN_W-1:0] len_reg, len_next;
    logic [15:0]               crc_reg, crc_next;
    logic [7:0]                prev_reg;
    logic                      good_reg, good_next;
    logic                      ignore_reg, ignore_next;
    logic [sfd_pkg::CNT_W-1:0] ptr_reg, ptr_next;
    logic [7:0]                rd_data_reg;
    logic                      out_valid_reg, out_valid_next;
    logic [7:0]                out_byte_reg;
    logic                      out_last_reg;
    logic                      out_good_reg;
    logic [sfd_pkg::CNT_W-1:0] last_idx;
    logic                      crc_feed_en;

    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15])
            begin
                c = {c[14:0], 1'b0} ^ sfd_pkg::CRC_POLY;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

    assign last_idx = sfd_pkg::CNT_W'(len_reg)
                    + sfd_pkg::CNT_W'(sfd_pkg::HDR_BYTES + sfd_pkg::CRC_BYTES - 1);

    assign crc_feed_en = (count_reg < sfd_pkg::CNT_W'(sfd_pkg::HDR_BYTES))
                      || (count_reg < sfd_pkg::CNT_W'(len_reg)
                                      + sfd_pkg::CNT_W'(sfd_pkg::HDR_BYTES));

    always_comb
    begin
        status.is_start   = (rx_byte == sfd_pkg::START_BYTE);
        status.lead_ok    = (rx_byte == sfd_pkg::LEAD_BYTE);
        status.first_byte = (count_reg == '0);
        status.len_byte   = (count_reg == sfd_pkg::CNT_W'(sfd_pkg::HDR_BYTES - 1));
        status.len_bad    = (rx_byte == 8'd0) || (rx_byte > 8'(sfd_pkg::MAX_PAYLOAD));
        status.frame_end  = (len_reg != '0) && (count_reg == last_idx);
        status.crc_match  = ({prev_reg, rx_byte} == crc_reg);
        status.ignore     = ignore_reg;
        status.rd_last    = (ptr_reg == last_idx);
        status.out_free   = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        count_next     = count_reg;
        len_next       = len_reg;
        crc_next       = crc_reg;
        good_next      = good_reg;
        ignore_next    = cfg_write_en ? cfg_write_data : ignore_reg;
        ptr_next       = ptr_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (cmd.clear)
        begin
            count_next = '0;
            len_next   = '0;
            crc_next   = sfd_pkg::CRC_INIT;
        end
        if (cmd.accept)
        begin
            count_next = count_reg + 1'b1;
            if (crc_feed_en)
            begin
                crc_next = crc_feed(crc_reg, rx_byte);
            end
        end
        if (cmd.set_len)
        begin
            len_next = sfd_pkg::LEN_W'(rx_byte);
        end
        if (cmd.latch_good)
        begin
            good_next = status.crc_match;
        end
        if (cmd.rd_start)
        begin
            ptr_next = '0;
        end
        if (cmd.load_out)
        begin
            ptr_next       = ptr_reg + 1'b1;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            len_reg       <= '0;
            crc_reg       <= sfd_pkg::CRC_INIT;
            good_reg      <= 1'b0;
            ignore_reg    <= 1'b0;
            ptr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            len_reg       <= len_next;
            crc_reg       <= crc_next;
            good_reg      <= good_next;
            ignore_reg    <= ignore_next;
            ptr_reg       <= ptr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // frame store, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            store_mem[count_reg] <= rx_byte;
            prev_reg             <= rx_byte;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= store_mem[ptr_reg];
        end
        if (cmd.load_out)
        begin
            out_byte_reg <= rd_data_reg;
            out_last_reg <= status.rd_last;
            out_good_reg <= good_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign frame_byte    = out_byte_reg;
    assign last_of_frame = out_last_reg;
    assign crc_good      = out_good_reg;

endmodule

>>> rtl/sfd_ctrl.sv
// sfd_ctrl: state machine that hunts, receives, checks and replays frames
// depends on sfd_pkg
module sfd_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  sfd_pkg::status_t status,
    output sfd_pkg::cmd_t    cmd
);

    sfd_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sfd_pkg::ST_HUNT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            sfd_pkg::ST_HUNT:
            begin
                in_ready = 1'b1;
                if (in_valid && status.is_start)
                begin
                    cmd.clear  = 1'b1;
                    state_next = sfd_pkg::ST_RECV;
                end
            end
            sfd_pkg::ST_RECV:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (status.first_byte && !status.lead_ok)
                    begin
                        state_next = sfd_pkg::ST_HUNT;
                    end
                    else if (status.len_byte)
                    begin
                        if (status.len_bad)
                        begin
                            state_next = sfd_pkg::ST_HUNT;
                        end
                        else
                        begin
                            cmd.set_len = 1'b1;
                        end
                    end
                    else if (status.frame_end)
                    begin
                        cmd.latch_good = 1'b1;
                        if (status.crc_match || status.ignore)
                        begin
                            cmd.rd_start = 1'b1;
                            state_next   = sfd_pkg::ST_FETCH;
                        end
                        else
                        begin
                            state_next = sfd_pkg::ST_HUNT;
                        end
                    end
                end
            end
            sfd_pkg::ST_FETCH:
            begin
                cmd.rd_en  = 1'b1;
                state_next = sfd_pkg::ST_LOAD;
            end
            sfd_pkg::ST_LOAD:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = status.rd_last ? sfd_pkg::ST_HUNT : sfd_pkg::ST_FETCH;
                end
            end
            default:
            begin
                state_next = sfd_pkg::ST_HUNT;
            end
        endcase
    end

endmodule
